// ===== rtl/dpsm_pkg.sv =====
`timescale 1ns / 1ps

package dpsm_pkg;

   localparam int SLOTS      = 16;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int SURF_W     = 32;
   localparam int POC_W      = 32;
   localparam int FNUM_W     = 16;
   localparam int RSP_SLOT_W = 4;
   localparam int RSP_MASK_W = 16;

   localparam logic [SURF_W-1:0] NO_SURFACE = '1;

   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_REF    = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   // request fields held steady for the whole scan
   typedef struct packed {
      op_type              op;
      logic [SURF_W-1:0]   surface;
      logic [POC_W-1:0]    poc;
      logic                long_ref;
      logic                entry_valid;
      logic                last;
      logic [IDX_W-1:0]    cur_slot;
      logic                cur_valid;
   } dpsm_cmd_type;

   // slot write issued at the end of a begin-picture scan
   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    idx;
      logic [SURF_W-1:0]   surface;
      logic [POC_W-1:0]    poc;
      logic [FNUM_W-1:0]   fnum;
   } dpsm_wr_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic                valid;
      logic                found;
      logic [IDX_W-1:0]    found_idx;
      logic [POC_W-1:0]    found_poc;
      logic [FNUM_W-1:0]   found_fnum;
      logic                found_lt;
      logic                free_found;
      logic [IDX_W-1:0]    free_idx;
      logic                min_valid;
      logic [IDX_W-1:0]    min_idx;
      logic [POC_W-1:0]    min_poc;
      logic [SLOTS-1:0]    freed;
   } dpsm_token_type;

endpackage

// ===== rtl/dpsm_cell.sv =====
`timescale 1ns / 1ps

// One picture slot plus one stage of the scan chain.
module dpsm_cell
   import dpsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     cell_index,
   input  dpsm_cmd_type         cmd,
   input  dpsm_wr_type          wr,
   input  dpsm_token_type       tok_in,
   output dpsm_token_type       tok_out
);

   logic [SURF_W-1:0] surface_ff, surface_in;
   logic              used_ff, used_in;
   logic [POC_W-1:0]  poc_ff, poc_in;
   logic [FNUM_W-1:0] fnum_ff, fnum_in;
   logic              lt_ff, lt_in;
   logic              keep_ff, keep_in;
   dpsm_token_type    tok_ff, tok_in_next;

   logic match;
   logic is_current;
   logic kept;

   assign match      = used_ff && (surface_ff == cmd.surface);
   assign is_current = cmd.cur_valid && (cmd.cur_slot == cell_index);

   always_comb begin
      tok_in_next = tok_in;
      surface_in  = surface_ff;
      used_in     = used_ff;
      poc_in      = poc_ff;
      fnum_in     = fnum_ff;
      lt_in       = lt_ff;
      keep_in     = keep_ff;
      kept        = 1'b0;

      if (tok_in.valid) begin
         unique case (cmd.op)
            OP_BEGIN: begin
               if (match && !tok_in.found) begin
                  tok_in_next.found     = 1'b1;
                  tok_in_next.found_idx = cell_index;
               end
               if (!used_ff && !tok_in.free_found) begin
                  tok_in_next.free_found = 1'b1;
                  tok_in_next.free_idx   = cell_index;
               end
               // strict less-than keeps the lowest index on a tie
               if (!tok_in.min_valid || ($signed(poc_ff) < $signed(tok_in.min_poc))) begin
                  tok_in_next.min_valid = 1'b1;
                  tok_in_next.min_idx   = cell_index;
                  tok_in_next.min_poc   = poc_ff;
               end
            end
            OP_REF: begin
               if (cmd.entry_valid && match) begin
                  if (!tok_in.found) begin
                     tok_in_next.found     = 1'b1;
                     tok_in_next.found_idx = cell_index;
                  end
                  keep_in = 1'b1;
                  poc_in  = cmd.poc;
                  lt_in   = cmd.long_ref;
               end
               if (cmd.last) begin
                  kept = keep_in || is_current;
                  if (used_ff && !kept) begin
                     used_in                       = 1'b0;
                     tok_in_next.freed[cell_index] = 1'b1;
                  end
                  keep_in = 1'b0;
               end
            end
            OP_LOOKUP: begin
               if (match && !tok_in.found) begin
                  tok_in_next.found      = 1'b1;
                  tok_in_next.found_idx  = cell_index;
                  tok_in_next.found_poc  = poc_ff;
                  tok_in_next.found_fnum = fnum_ff;
                  tok_in_next.found_lt   = lt_ff;
               end
            end
            default: begin
            end
         endcase
      end

      if (wr.en && (wr.idx == cell_index)) begin
         surface_in = wr.surface;
         poc_in     = wr.poc;
         fnum_in    = wr.fnum;
         used_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_ff   <= NO_SURFACE;
         used_ff      <= 1'b0;
         poc_ff       <= '0;
         fnum_ff      <= '0;
         lt_ff        <= 1'b0;
         keep_ff      <= 1'b0;
         tok_ff       <= '0;
      end else begin
         surface_ff   <= surface_in;
         used_ff      <= used_in;
         poc_ff       <= poc_in;
         fnum_ff      <= fnum_in;
         lt_ff        <= lt_in;
         keep_ff      <= keep_in;
         tok_ff       <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/decoded_picture_slot_manager.sv =====
`timescale 1ns / 1ps

// Channel   Ports                        Handshake
// --------  ---------------------------  ---------------------------------------
// request   start, busy, req_*           taken at a clock edge with start & !busy
// result    rsp_strobe, rsp_*            one cycle wide, always taken
//
// A request passes the launch register, each slot cell's token register in turn
// and the result registers before the strobe; busy drops with the strobe, so a
// new request can be accepted in the strobe cycle. The scan token walks the row
// of slot cells, one cell per cycle. Reset is synchronous and empties every
// slot. The receiver cannot stall; results are never held back or dropped.
module decoded_picture_slot_manager
   import dpsm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_op,
   input  logic [SURF_W-1:0]       req_surface,
   input  logic signed [POC_W-1:0] req_poc,
   input  logic [FNUM_W-1:0]       req_frame_number,
   input  logic                    req_long_term,
   input  logic                    req_entry_valid,
   input  logic                    req_last,
   output logic                    rsp_strobe,
   output logic [RSP_SLOT_W-1:0]   rsp_slot,
   output logic                    rsp_hit,
   output logic                    rsp_evicted,
   output logic signed [POC_W-1:0] rsp_slot_poc,
   output logic [FNUM_W-1:0]       rsp_slot_frame_number,
   output logic                    rsp_slot_long_term,
   output logic [RSP_MASK_W-1:0]   rsp_freed_mask
);

   // request hold registers: stable for the whole scan
   logic              busy_ff, busy_in;
   logic              launch_ff, launch_in;
   logic [1:0]        op_ff, op_in;
   logic [SURF_W-1:0] surface_ff, surface_in;
   logic [POC_W-1:0]  poc_ff, poc_in;
   logic [FNUM_W-1:0] fnum_ff, fnum_in;
   logic              lt_ff, lt_in;
   logic              ev_ff, ev_in;
   logic              last_ff, last_in;

   // current picture
   logic [IDX_W-1:0]  cur_slot_ff, cur_slot_in;
   logic              cur_valid_ff, cur_valid_in;

   // result registers
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [RSP_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic [POC_W-1:0]      rsp_poc_ff, rsp_poc_in;
   logic [FNUM_W-1:0]     rsp_fnum_ff, rsp_fnum_in;
   logic                  rsp_lt_ff, rsp_lt_in;
   logic [RSP_MASK_W-1:0] rsp_freed_ff, rsp_freed_in;

   logic             accept;
   logic             done;
   op_type           op_cur;
   logic [IDX_W-1:0] pick;
   logic             evict;
   dpsm_cmd_type     cmd;
   dpsm_wr_type      wr;
   dpsm_token_type   tok_head;
   dpsm_token_type   tok [SLOTS+1];
   dpsm_token_type   tok_end;
   logic [SLOTS:0]   tok_valid;

   assign accept = start && !busy_ff;
   assign op_cur = op_type'(op_ff);

   // broadcast the held request to every cell
   assign cmd.op          = op_cur;
   assign cmd.surface     = surface_ff;
   assign cmd.poc         = poc_ff;
   assign cmd.long_ref    = lt_ff;
   assign cmd.entry_valid = ev_ff;
   assign cmd.last        = last_ff;
   assign cmd.cur_slot    = cur_slot_ff;
   assign cmd.cur_valid   = cur_valid_ff;

   // launch an empty token into the head of the chain
   always_comb begin
      tok_head       = '0;
      tok_head.valid = launch_ff;
   end

   assign tok[0] = tok_head;

   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_cell
         dpsm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (IDX_W'(gi)),
            .cmd        (cmd),
            .wr         (wr),
            .tok_in     (tok[gi]),
            .tok_out    (tok[gi+1])
         );
      end
      for (gi = 0; gi <= SLOTS; gi++) begin : g_tv
         assign tok_valid[gi] = tok[gi].valid;
      end
   endgenerate

   assign tok_end = tok[SLOTS];
   assign done    = tok_end.valid;

   // begin picture: own slot first, then lowest free, then oldest order count
   always_comb begin
      evict = 1'b0;
      priority if (tok_end.found) begin
         pick = tok_end.found_idx;
      end else if (tok_end.free_found) begin
         pick = tok_end.free_idx;
      end else begin
         pick  = tok_end.min_idx;
         evict = 1'b1;
      end
   end

   // write the chosen slot as the token leaves the chain
   assign wr.en      = done && (op_cur == OP_BEGIN);
   assign wr.idx     = pick;
   assign wr.surface = surface_ff;
   assign wr.poc     = poc_ff;
   assign wr.fnum    = fnum_ff;

   always_comb begin
      busy_in      = busy_ff;
      launch_in    = accept;
      op_in        = op_ff;
      surface_in   = surface_ff;
      poc_in       = poc_ff;
      fnum_in      = fnum_ff;
      lt_in        = lt_ff;
      ev_in        = ev_ff;
      last_in      = last_ff;
      cur_slot_in  = cur_slot_ff;
      cur_valid_in = cur_valid_ff;

      rsp_strobe_in  = 1'b0;
      rsp_slot_in    = rsp_slot_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_poc_in     = rsp_poc_ff;
      rsp_fnum_in    = rsp_fnum_ff;
      rsp_lt_in      = rsp_lt_ff;
      rsp_freed_in   = rsp_freed_ff;

      // capture the request and start the scan
      if (accept) begin
         busy_in    = 1'b1;
         op_in      = req_op;
         surface_in = req_surface;
         poc_in     = req_poc;
         fnum_in    = req_frame_number;
         lt_in      = req_long_term;
         ev_in      = req_entry_valid;
         last_in    = req_last;
      end

      // token has passed every cell: form the result
      if (done) begin
         busy_in        = 1'b0;
         rsp_strobe_in  = 1'b1;
         rsp_slot_in    = '0;
         rsp_hit_in     = 1'b0;
         rsp_evicted_in = 1'b0;
         rsp_poc_in     = '0;
         rsp_fnum_in    = '0;
         rsp_lt_in      = 1'b0;
         rsp_freed_in   = '0;
         unique case (op_cur)
            OP_BEGIN: begin
               rsp_slot_in    = RSP_SLOT_W'(pick);
               rsp_evicted_in = evict;
               cur_slot_in    = pick;
               cur_valid_in   = 1'b1;
            end
            OP_REF: begin
               if (tok_end.found) begin
                  rsp_slot_in = RSP_SLOT_W'(tok_end.found_idx);
                  rsp_hit_in  = 1'b1;
               end
               rsp_freed_in = RSP_MASK_W'(tok_end.freed);
            end
            OP_LOOKUP: begin
               if (tok_end.found) begin
                  rsp_slot_in = RSP_SLOT_W'(tok_end.found_idx);
                  rsp_hit_in  = 1'b1;
                  rsp_poc_in  = tok_end.found_poc;
                  rsp_fnum_in = tok_end.found_fnum;
                  rsp_lt_in   = tok_end.found_lt;
               end
            end
            default: begin
               // unused code: all-zero result, no state change
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         launch_ff     <= 1'b0;
         cur_slot_ff   <= '0;
         cur_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         launch_ff     <= launch_in;
         cur_slot_ff   <= cur_slot_in;
         cur_valid_ff  <= cur_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      surface_ff     <= surface_in;
      poc_ff         <= poc_in;
      fnum_ff        <= fnum_in;
      lt_ff          <= lt_in;
      ev_ff          <= ev_in;
      last_ff        <= last_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_poc_ff     <= rsp_poc_in;
      rsp_fnum_ff    <= rsp_fnum_in;
      rsp_lt_ff      <= rsp_lt_in;
      rsp_freed_ff   <= rsp_freed_in;
   end

   assign busy                  = busy_ff;
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_slot              = rsp_slot_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_evicted           = rsp_evicted_ff;
   assign rsp_slot_poc          = rsp_poc_ff;
   assign rsp_slot_frame_number = rsp_fnum_ff;
   assign rsp_slot_long_term    = rsp_lt_ff;
   assign rsp_freed_mask        = rsp_freed_ff;

`ifndef SYNTH
   // at most one scan token in the chain at a time
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one scan token in flight");

   // a token in the chain implies the block reports busy
   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      (tok_valid != '0) |-> busy_ff)
      else $error("scan token present while idle");

   // every result closes a scan
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(done))
      else $error("result strobe without a finished scan");

   // a begin-picture write makes the current picture valid
   a_begin_current: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> (cur_valid_ff && (cur_slot_ff == $past(wr.idx))))
      else $error("current picture not updated on begin");

   // slots are released only by the last item of a reference list
   a_freed_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_freed_ff != '0)) |-> ($past(op_cur == OP_REF) && $past(last_ff)))
      else $error("slots released outside a reference list end");
`endif

endmodule
